// ===== hw/rtl/zzrld_pkg.sv =====
package zzrld_pkg;

    localparam int          WORD_W    = 16;
    localparam int          STRIDE_W  = 13;
    localparam int          OFFSET_W  = 15;
    localparam int          COUNT_W   = 6;
    localparam logic [3:0]  FILL_RUN  = 4'hF;
    localparam logic [COUNT_W-1:0] BLOCK_LAST = 6'd63;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd8;

    // diagonal scan order, every diagonal walked with x falling: scan index -> raster position (y*8 + x)
    localparam logic [5:0] SCAN_POS [64] = '{
        6'd0,  6'd1,  6'd8,  6'd2,  6'd9,  6'd16, 6'd3,  6'd10,
        6'd17, 6'd24, 6'd4,  6'd11, 6'd18, 6'd25, 6'd32, 6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd6,  6'd13, 6'd20,
        6'd27, 6'd34, 6'd41, 6'd48, 6'd7,  6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd15, 6'd22, 6'd29, 6'd36,
        6'd43, 6'd50, 6'd57, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd31, 6'd38, 6'd45, 6'd52, 6'd59, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd47, 6'd54, 6'd61, 6'd55, 6'd62, 6'd63
    };

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture a new code word
        logic step;   // produce one result into the output register
    } zzrld_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic final_res; // the result being produced ends the current word
    } zzrld_status_t;

endpackage

// ===== hw/rtl/zzrld_ctrl.sv =====
module zzrld_ctrl
    import zzrld_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  zzrld_status_t status,
    output zzrld_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    // word intake only between words
    assign s_ready  = (state_reg == ST_IDLE);
    assign cmd.load = (state_reg == ST_IDLE) && s_valid;
    assign cmd.step = (state_reg == ST_EMIT) && status.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free && status.final_res) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/zzrld_datapath.sv =====
module zzrld_datapath
    import zzrld_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  zzrld_cmd_t                 cmd,
    output zzrld_status_t              status,
    input  logic signed [WORD_W-1:0]   s_code_word,
    input  logic                       cfg_valid,
    input  logic [STRIDE_W-1:0]        cfg_line_stride,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_is_header,
    output logic signed [WORD_W-1:0]   m_coeff_value,
    output logic [OFFSET_W-1:0]        m_element_offset,
    output logic                       m_last_of_run,
    output logic                       m_block_done,
    output logic                       m_overrun
);

    // control state
    logic                 hdr_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [STRIDE_W-1:0]  stride_reg;
    logic                 m_valid_reg;

    // payload state
    logic [WORD_W-1:0]    word_reg;
    logic [3:0]           zeros_reg;
    logic                 is_header_reg;
    logic [WORD_W-1:0]    value_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic                 last_reg;
    logic                 done_reg;
    logic                 over_reg;

    logic                 fill;
    logic                 zeros_pending;
    logic                 is_zero;
    logic                 at_end;
    logic                 final_res;
    logic [5:0]           pos;
    logic [15:0]          prod;
    logic [OFFSET_W-1:0]  offset;
    logic [WORD_W-1:0]    coeff_sext;

    // decode of the current step
    assign fill          = (word_reg[3:0] == FILL_RUN);
    assign zeros_pending = (zeros_reg != 4'd0);
    assign is_zero       = fill || zeros_pending;
    assign at_end        = (count_reg == BLOCK_LAST);
    assign final_res     = hdr_reg || at_end || !is_zero;
    assign coeff_sext    = {{4{word_reg[WORD_W-1]}}, word_reg[WORD_W-1:4]};

    // raster offset x + y*stride, wrapped to 15 bits
    assign pos    = SCAN_POS[count_reg];
    assign prod   = {13'd0, pos[5:3]} * {3'd0, stride_reg};
    assign offset = prod[OFFSET_W-1:0] + {12'd0, pos[2:0]};

    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.final_res = final_res;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg     <= 1'b1;
            count_reg   <= '0;
            stride_reg  <= STRIDE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                stride_reg <= cfg_line_stride;
            end
            if (cmd.step) begin
                m_valid_reg <= 1'b1;
                if (hdr_reg) begin
                    hdr_reg   <= 1'b0;
                    count_reg <= '0;
                end else begin
                    count_reg <= count_reg + 1'b1;
                    if (at_end) begin
                        hdr_reg <= 1'b1;
                    end
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // word capture, run countdown and output register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            word_reg  <= s_code_word;
            zeros_reg <= s_code_word[3:0];
        end else if (cmd.step && !hdr_reg && !fill && zeros_pending) begin
            zeros_reg <= zeros_reg - 4'd1;
        end
        if (cmd.step) begin
            if (hdr_reg) begin
                is_header_reg <= 1'b1;
                value_reg     <= word_reg;
                offset_reg    <= '0;
                last_reg      <= 1'b1;
                done_reg      <= 1'b0;
                over_reg      <= 1'b0;
            end else begin
                is_header_reg <= 1'b0;
                value_reg     <= is_zero ? '0 : coeff_sext;
                offset_reg    <= offset;
                last_reg      <= final_res;
                done_reg      <= at_end;
                // coefficient dropped when its zeros already reach the block end
                over_reg      <= at_end && !fill && zeros_pending;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_is_header      = is_header_reg;
    assign m_coeff_value    = value_reg;
    assign m_element_offset = offset_reg;
    assign m_last_of_run    = last_reg;
    assign m_block_done     = done_reg;
    assign m_overrun        = over_reg;

endmodule

// ===== hw/rtl/zigzag_run_length_decoder_core.sv =====
// Zigzag run-length decoder for 8x8 blocks. The first code word of a block is
// passed out as a header result; each later word yields its zero run followed
// by its coefficient (run 15 fills the block with zeros), each at the raster
// offset x + y*line_stride of the next scan position. A run that reaches past
// position 63 is cut there and its last result flags overrun. Results leave one
// per cycle through the single result register stepped by the controller, as
// long as m_ready does not stall it. A header word yields one result, a run
// word up to 15 and a fill from the start of a block up to 64. The next word
// is taken once the last result of the current word is in that register. The
// user must write line_stride on the cfg port only while the block is idle;
// the block itself does not enforce this. The cfg port is always ready.
module zigzag_run_length_decoder_core
    import zzrld_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [STRIDE_W-1:0]        cfg_line_stride,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [WORD_W-1:0]   s_code_word,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_is_header,
    output logic signed [WORD_W-1:0]   m_coeff_value,
    output logic [OFFSET_W-1:0]        m_element_offset,
    output logic                       m_last_of_run,
    output logic                       m_block_done,
    output logic                       m_overrun
);

    zzrld_cmd_t    cmd;
    zzrld_status_t status;

    assign cfg_ready = 1'b1;

    zzrld_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    zzrld_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_code_word      (s_code_word),
        .cfg_valid        (cfg_valid),
        .cfg_line_stride  (cfg_line_stride),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_header      (m_is_header),
        .m_coeff_value    (m_coeff_value),
        .m_element_offset (m_element_offset),
        .m_last_of_run    (m_last_of_run),
        .m_block_done     (m_block_done),
        .m_overrun        (m_overrun)
    );

endmodule

// ===== hw/rtl/zzrld_checker.sv =====
module zzrld_checker
    import zzrld_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_is_header,
    input  logic signed [WORD_W-1:0]   m_coeff_value,
    input  logic [OFFSET_W-1:0]        m_element_offset,
    input  logic                       m_last_of_run,
    input  logic                       m_block_done,
    input  logic                       m_overrun
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coeff_value)
            && $stable(m_element_offset) && $stable(m_last_of_run))
        else $error("result changed while stalled");

    // header results sit at offset zero and close their word alone
    a_header_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_header |-> m_element_offset == '0 && m_last_of_run
            && !m_block_done && !m_overrun)
        else $error("malformed header result");

    // block end always closes the word; overrun only at block end
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_block_done || m_overrun) |-> m_last_of_run && m_block_done)
        else $error("block end flags inconsistent");

    // once a completed block is taken, the following sample shows no result or a header
    a_header_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_block_done |=> !m_valid || m_is_header)
        else $error("no header after block end");

endmodule

bind zigzag_run_length_decoder_core zzrld_checker u_zzrld_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_is_header      (m_is_header),
    .m_coeff_value    (m_coeff_value),
    .m_element_offset (m_element_offset),
    .m_last_of_run    (m_last_of_run),
    .m_block_done     (m_block_done),
    .m_overrun        (m_overrun)
);

// ===== test/tb_zigzag_run_length_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_zigzag_run_length_decoder_core;
    import zzrld_pkg::*;

    localparam int BLOCK_COEFFS = 64;
    localparam int SETTLE_CYCLES = 20;
    localparam int PRINT_LIMIT = 50;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic                is_header;
        logic [WORD_W-1:0]   coeff_value;
        logic [OFFSET_W-1:0] element_offset;
        logic                last_of_run;
        logic                block_done;
        logic                overrun;
    } coeff_result_t;

    // DUT ports
    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [STRIDE_W-1:0]      cfg_line_stride = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [WORD_W-1:0] s_code_word = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_is_header;
    logic signed [WORD_W-1:0] m_coeff_value;
    logic [OFFSET_W-1:0]      m_element_offset;
    logic                     m_last_of_run;
    logic                     m_block_done;
    logic                     m_overrun;

    // stimulus and expectation stores
    logic [WORD_W-1:0] code_word_q[$];
    coeff_result_t     coeff_expect_q[$];
    int                words_fed = 0;
    int                words_taken = 0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                mismatch_count = 0;

    // decoder state mirror
    logic [STRIDE_W-1:0] stride_mirror = STRIDE_RESET;
    int                  coeffs_in_block = 0;
    logic                header_due = 1'b1;

    zigzag_run_length_decoder_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_line_stride  (cfg_line_stride),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_code_word      (s_code_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_header      (m_is_header),
        .m_coeff_value    (m_coeff_value),
        .m_element_offset (m_element_offset),
        .m_last_of_run    (m_last_of_run),
        .m_block_done     (m_block_done),
        .m_overrun        (m_overrun)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("ERROR %0t ns: %s", $time, what);
        end
    endtask

    // raster offset of a scan index: diagonals walked with x falling, y rising
    function automatic logic [OFFSET_W-1:0] scan_offset(input int idx);
        int k;
        int px;
        int py;
        k = 0;
        px = 0;
        py = 0;
        for (int d = 0; d < 15; d++) begin
            for (int y = (d > 7) ? d - 7 : 0; y <= ((d < 7) ? d : 7); y++) begin
                if (k == idx) begin
                    px = d - y;
                    py = y;
                end
                k++;
            end
        end
        return OFFSET_W'(px + py * int'(stride_mirror));
    endfunction

    // expected results of one accepted code word
    function automatic void decode_word(input logic [WORD_W-1:0] word);
        coeff_result_t r;
        logic [3:0]    run;
        logic [WORD_W-1:0] coeff;
        int            zeros;
        int            total;
        logic          has_coeff;
        logic          cut;
        int            room;
        if (header_due) begin
            r = '{1'b1, word, '0, 1'b1, 1'b0, 1'b0};
            coeff_expect_q.push_back(r);
            header_due = 1'b0;
            coeffs_in_block = 0;
            return;
        end
        run = word[3:0];
        coeff = {{4{word[WORD_W-1]}}, word[WORD_W-1:4]};
        if (coeffs_in_block >= BLOCK_COEFFS) coeffs_in_block = 0;
        room = BLOCK_COEFFS - coeffs_in_block;
        cut = 1'b0;
        if (run == FILL_RUN) begin
            zeros = room;
            has_coeff = 1'b0;
        end else if (int'(run) >= room) begin
            zeros = room;
            has_coeff = 1'b0;
            cut = 1'b1;
        end else begin
            zeros = run;
            has_coeff = 1'b1;
        end
        total = zeros + int'(has_coeff);
        for (int k = 0; k < total; k++) begin
            r.is_header      = 1'b0;
            r.coeff_value    = (k == zeros) ? coeff : '0;
            r.element_offset = scan_offset(coeffs_in_block);
            coeffs_in_block++;
            r.last_of_run    = (k == total - 1);
            r.block_done     = r.last_of_run && coeffs_in_block == BLOCK_COEFFS;
            r.overrun        = r.block_done && cut;
            coeff_expect_q.push_back(r);
        end
        if (coeffs_in_block >= BLOCK_COEFFS) begin
            coeffs_in_block = 0;
            header_due = 1'b1;
        end
    endfunction

    task automatic check_result(input coeff_result_t want);
        if (m_is_header !== want.is_header)
            report_mismatch($sformatf("is_header %b, expected %b", m_is_header, want.is_header));
        if (m_coeff_value !== want.coeff_value)
            report_mismatch($sformatf("coeff_value %h, expected %h",
                                      m_coeff_value, want.coeff_value));
        if (m_element_offset !== want.element_offset)
            report_mismatch($sformatf("element_offset %0d, expected %0d",
                                      m_element_offset, want.element_offset));
        if (m_last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      m_last_of_run, want.last_of_run));
        if (m_block_done !== want.block_done)
            report_mismatch($sformatf("block_done %b, expected %b",
                                      m_block_done, want.block_done));
        if (m_overrun !== want.overrun)
            report_mismatch($sformatf("overrun %b, expected %b", m_overrun, want.overrun));
    endtask

    // rising edge: register writes, word transfers and result transfers
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) stride_mirror = cfg_line_stride;
            if (s_valid && s_ready) begin
                decode_word(s_code_word);
                words_taken++;
            end
            if (m_valid && m_ready) begin
                if (coeff_expect_q.size() == 0) report_mismatch("result with nothing expected");
                else check_result(coeff_expect_q.pop_front());
            end
        end
    end

    // falling edge: present the next word, randomize the result stall
    always @(negedge aclk) begin
        if (aresetn && words_taken == words_fed) begin
            if (code_word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_code_word <= code_word_q.pop_front();
                s_valid <= 1'b1;
                words_fed++;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    task automatic set_idle(input idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SEND) ? 79 : (mode == IDLE_BOTH) ? 17 : 0;
        stall_pct     = (mode == IDLE_RECV) ? 79 : (mode == IDLE_BOTH) ? 17 : 0;
    endtask

    task automatic write_stride(input logic [STRIDE_W-1:0] stride);
        cfg_line_stride <= stride;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every word is taken and every result has come back
    task automatic drain();
        while (code_word_q.size() != 0 || words_taken != words_fed || s_valid
               || coeff_expect_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // field extremes, overrun, exact fit and fill from an empty block
    task automatic queue_directed();
        code_word_q.push_back(16'h8000);
        code_word_q.push_back(16'h7FF0);
        code_word_q.push_back(16'h800E);
        code_word_q.push_back(16'hFFF0);
        code_word_q.push_back(16'h0011);
        code_word_q.push_back(16'hFFFF);
        code_word_q.push_back(16'h7FFF);
        repeat (4) code_word_q.push_back(16'h123E);
        code_word_q.push_back(16'hABCE);
        code_word_q.push_back(16'h0000);
        repeat (4) code_word_q.push_back(16'h001E);
        code_word_q.push_back(16'h5553);
        code_word_q.push_back(16'hFFFF);
        code_word_q.push_back({12'h000, FILL_RUN});
    endtask

    // whole blocks of random content: header, then runs until 64 coefficients
    task automatic queue_random_blocks(input int n_words);
        int               queued;
        int               filled;
        int               pick;
        logic [WORD_W-1:0] w;
        queued = 0;
        while (queued < n_words) begin
            code_word_q.push_back(WORD_W'($urandom));
            queued++;
            filled = 0;
            while (filled < BLOCK_COEFFS) begin
                w = WORD_W'($urandom);
                pick = $urandom_range(99);
                if (pick < 6) w[3:0] = FILL_RUN;
                else if (pick < 85 && w[3:0] == FILL_RUN) w[3:0] = 4'($urandom_range(14));
                code_word_q.push_back(w);
                queued++;
                if (w[3:0] == FILL_RUN || int'(w[3:0]) >= BLOCK_COEFFS - filled)
                    filled = BLOCK_COEFFS;
                else
                    filled += int'(w[3:0]) + 1;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset stride, no idling
        set_idle(IDLE_NONE);
        queue_directed();
        drain();

        write_stride(13'd4096);
        queue_random_blocks(40);
        drain();

        write_stride(13'd0);
        set_idle(IDLE_SEND);
        queue_random_blocks(40);
        drain();

        write_stride(13'h1FFF);
        set_idle(IDLE_RECV);
        queue_random_blocks(40);
        drain();

        write_stride(STRIDE_W'($urandom_range(4096, 8)));
        set_idle(IDLE_BOTH);
        queue_random_blocks(40);
        drain();

        write_stride(13'd8);
        queue_directed();
        queue_random_blocks(20);
        drain();

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run timeout
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
